// File: sv/cbrf_pkg.sv
// ----------------------------------------------------------------------------
// cbrf_pkg
// Shared widths, register map and control groups for the cubic bisection
// root finder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbrf_pkg;

  // endpoint format: signed fixed point
  localparam int X_W     = 24;
  localparam int FRAC    = 16;
  localparam int C_W     = 16;
  localparam int TOL_W   = 24;

  // Horner accumulator, wide enough for c*x^3 scaled by 2^(3*FRAC)
  localparam int MAXXF   = (X_W > FRAC) ? X_W : FRAC;
  localparam int ACC_W   = 3 * MAXXF + C_W + 3;

  // shared multiplier: one CH_W x X_W partial product per cycle in its multiply state
  localparam int CH_W    = 32;
  localparam int NCH     = (ACC_W + CH_W - 1) / CH_W;
  localparam int MAG_W   = NCH * CH_W;
  localparam int PROD_W  = CH_W + X_W;
  localparam int CNT_W   = (NCH > 1) ? $clog2(NCH) : 1;

  // width compare and result conversion
  localparam int WID_W   = X_W + 1;
  localparam int CMP_W   = (WID_W > TOL_W) ? WID_W : TOL_W;
  localparam int VAL_W   = 64;
  localparam int WIDE_W  = (ACC_W > VAL_W) ? ACC_W : VAL_W + 1;

  // stream words, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * X_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((X_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  // configuration port
  localparam int NREG    = 5;
  localparam int ADDR_W  = $clog2(4 * NREG);
  localparam int DATA_W  = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

  typedef enum logic [2:0] {
    REG_CUBIC  = 3'd0,
    REG_SQUARE = 3'd1,
    REG_LINEAR = 3'd2,
    REG_CONST  = 3'd3,
    REG_TOL    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [C_W-1:0] c3;
    logic signed [C_W-1:0] c2;
    logic signed [C_W-1:0] c1;
    logic signed [C_W-1:0] c0;
  } coeff_t;

  typedef struct packed {
    logic           start;
    logic [X_W-1:0] x;
  } eval_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] value;
  } eval_rsp_t;

endpackage

`default_nettype wire

// File: sv/cubic_bisection_root_finder.sv
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder
// Bisection search for a root of c3*x^3 + c2*x^2 + c1*x + c0 between two
// fixed-point endpoints, coefficients and stop width set over APB.
// ----------------------------------------------------------------------------
// Halvings per word: up to about 23 at full range and the reset
//   tolerance.
// Each cubic evaluation runs three Horner steps through
//   one 32 x 24 multiplier working over the 3 chunks of the accumulator.
// Throughput: one word at a time; in_tready is high only while idle.
// Reset: synchronous, active low; coefficients clear, tolerance reads 7.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bisection_root_finder (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: lower_start, upper_start
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [cbrf_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: root_estimate, value_at_root
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [cbrf_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // out_tuser: exact_zero, bracket_error
  output logic [cbrf_pkg::OUT_TUSER_W-1:0]        out_tuser,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [cbrf_pkg::ADDR_W-1:0]        cfg_paddr,
  input  wire logic [cbrf_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [cbrf_pkg::DATA_W-1:0]             cfg_prdata,
  output logic                                    cfg_pready
);

  // sequencer: endpoint evaluations, then one pass per halving
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_LO_GO    = 9'b000000010,
    S_LO_WAIT  = 9'b000000100,
    S_HI_GO    = 9'b000001000,
    S_HI_WAIT  = 9'b000010000,
    S_SETUP    = 9'b000100000,
    S_MID_GO   = 9'b001000000,
    S_MID_WAIT = 9'b010000000,
    S_FIN      = 9'b100000000
  } state_t;

  state_t state_r;

  // configuration
  cbrf_pkg::coeff_t              coeff_r;
  logic [cbrf_pkg::TOL_W-1:0]    tol_r;
  logic                          cfg_we;
  cbrf_pkg::reg_idx_t            cfg_idx;

  // search state
  logic [cbrf_pkg::X_W-1:0]      lo_r;
  logic [cbrf_pkg::X_W-1:0]      hi_r;
  logic                          lo_pos_r;
  logic                          hi_pos_r;
  logic [cbrf_pkg::X_W-1:0]      mid_r;
  logic [cbrf_pkg::WID_W-1:0]    wid_r;
  logic                          zero_r;
  logic                          err_r;

  // output register
  logic                          out_valid_r;
  logic [cbrf_pkg::X_W-1:0]      out_root_r;
  logic [cbrf_pkg::VAL_W-1:0]    out_val_r;
  logic                          out_zero_r;
  logic                          out_err_r;

  cbrf_pkg::eval_req_t           ev_req;
  cbrf_pkg::eval_rsp_t           ev_rsp;

  logic                          val_zero;
  logic                          val_pos;
  logic                          mv_lo;
  logic                          mv_hi;
  logic                          bad;
  logic                          stop;
  logic                          finish;
  logic                          out_load;
  logic [cbrf_pkg::WID_W-1:0]    ends_sum;
  logic [cbrf_pkg::WID_W-1:0]    ends_diff;
  logic [cbrf_pkg::WID_W-1:0]    width_nxt;
  logic [cbrf_pkg::TOL_W-1:0]    tol_eff;

  // floor to FRAC fraction bits, then clamp into 64 bits
  function automatic logic [cbrf_pkg::VAL_W-1:0] to_fixed_sat(
    input logic [cbrf_pkg::ACC_W-1:0] v
  );
    logic [cbrf_pkg::ACC_W-1:0]  s;
    logic [cbrf_pkg::WIDE_W-1:0] e;
    logic                        fits;
    s    = $signed(v) >>> (2 * cbrf_pkg::FRAC);
    e    = cbrf_pkg::WIDE_W'($signed(s));
    fits = (&e[cbrf_pkg::WIDE_W-1:cbrf_pkg::VAL_W-1]) ||
           !(|e[cbrf_pkg::WIDE_W-1:cbrf_pkg::VAL_W-1]);
    if (fits) begin
      to_fixed_sat = e[cbrf_pkg::VAL_W-1:0];
    end else if (e[cbrf_pkg::WIDE_W-1]) begin
      to_fixed_sat = {1'b1, {(cbrf_pkg::VAL_W-1){1'b0}}};
    end else begin
      to_fixed_sat = {1'b0, {(cbrf_pkg::VAL_W-1){1'b1}}};
    end
  endfunction

  // ---------------------------------------------------------------- APB
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cbrf_pkg::reg_idx_t'(cfg_paddr[cbrf_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
      tol_r   <= cbrf_pkg::TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        cbrf_pkg::REG_CUBIC:  coeff_r.c3 <= cfg_pwdata[cbrf_pkg::C_W-1:0];
        cbrf_pkg::REG_SQUARE: coeff_r.c2 <= cfg_pwdata[cbrf_pkg::C_W-1:0];
        cbrf_pkg::REG_LINEAR: coeff_r.c1 <= cfg_pwdata[cbrf_pkg::C_W-1:0];
        cbrf_pkg::REG_CONST:  coeff_r.c0 <= cfg_pwdata[cbrf_pkg::C_W-1:0];
        cbrf_pkg::REG_TOL:    tol_r      <= cfg_pwdata[cbrf_pkg::TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cbrf_pkg::REG_CUBIC:  cfg_prdata = cbrf_pkg::DATA_W'($unsigned(coeff_r.c3));
      cbrf_pkg::REG_SQUARE: cfg_prdata = cbrf_pkg::DATA_W'($unsigned(coeff_r.c2));
      cbrf_pkg::REG_LINEAR: cfg_prdata = cbrf_pkg::DATA_W'($unsigned(coeff_r.c1));
      cbrf_pkg::REG_CONST:  cfg_prdata = cbrf_pkg::DATA_W'($unsigned(coeff_r.c0));
      cbrf_pkg::REG_TOL:    cfg_prdata = cbrf_pkg::DATA_W'(tol_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------- cubic evaluator
  assign ev_req.start = (state_r == S_LO_GO) || (state_r == S_HI_GO) ||
                        (state_r == S_MID_GO);
  assign ev_req.x     = (state_r == S_LO_GO) ? lo_r :
                        (state_r == S_HI_GO) ? hi_r : mid_r;

  cbrf_horner u_horner (
    .clk   (clk),
    .rst_n (rst_n),
    .coeff (coeff_r),
    .req   (ev_req),
    .rsp   (ev_rsp)
  );

  // sign class of the latest value: strictly positive or not
  assign val_zero = (ev_rsp.value == '0);
  assign val_pos  = !ev_rsp.value[cbrf_pkg::ACC_W-1] && !val_zero;

  // endpoint choice; the lower end is tried first
  assign mv_lo  = !val_zero && (val_pos == lo_pos_r);
  assign mv_hi  = !val_zero && !mv_lo && (val_pos == hi_pos_r);
  assign bad    = !val_zero && !mv_lo && !mv_hi;

  // zero tolerance behaves as one lsb
  assign tol_eff = (tol_r == '0) ? cbrf_pkg::TOL_W'(1) : tol_r;
  assign stop    = cbrf_pkg::CMP_W'(wid_r) <= cbrf_pkg::CMP_W'(tol_eff);
  assign finish  = val_zero || bad || stop;

  // floored midpoint and width of the interval before it is narrowed
  assign ends_sum  = {lo_r[cbrf_pkg::X_W-1], lo_r} + {hi_r[cbrf_pkg::X_W-1], hi_r};
  assign ends_diff = {lo_r[cbrf_pkg::X_W-1], lo_r} - {hi_r[cbrf_pkg::X_W-1], hi_r};
  assign width_nxt = ends_diff[cbrf_pkg::WID_W-1] ? (~ends_diff + 1'b1) : ends_diff;

  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // ----------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE:     if (in_tvalid) state_r <= S_LO_GO;
        S_LO_GO:    state_r <= S_LO_WAIT;
        S_LO_WAIT:  if (ev_rsp.done) state_r <= S_HI_GO;
        S_HI_GO:    state_r <= S_HI_WAIT;
        S_HI_WAIT:  if (ev_rsp.done) state_r <= S_SETUP;
        S_SETUP:    state_r <= S_MID_GO;
        S_MID_GO:   state_r <= S_MID_WAIT;
        S_MID_WAIT: begin
          if (ev_rsp.done) begin
            state_r <= finish ? S_FIN : S_SETUP;
          end
        end
        S_FIN:      if (out_load) state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          lo_r <= in_tdata[cbrf_pkg::X_W-1:0];
          hi_r <= in_tdata[2*cbrf_pkg::X_W-1:cbrf_pkg::X_W];
        end
      end
      S_LO_WAIT: if (ev_rsp.done) lo_pos_r <= val_pos;
      S_HI_WAIT: if (ev_rsp.done) hi_pos_r <= val_pos;
      S_SETUP: begin
        mid_r <= ends_sum[cbrf_pkg::WID_W-1:1];
        wid_r <= width_nxt;
      end
      S_MID_WAIT: begin
        if (ev_rsp.done) begin
          zero_r <= val_zero;
          err_r  <= bad;
          if (mv_lo) lo_r <= mid_r;
          if (mv_hi) hi_r <= mid_r;
        end
      end
      default: begin
      end
    endcase
  end

  // result word; the evaluator holds its value while the sequencer waits here
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_root_r <= mid_r;
      out_val_r  <= to_fixed_sat(ev_rsp.value);
      out_zero_r <= zero_r;
      out_err_r  <= err_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = cbrf_pkg::OUT_TDATA_W'({out_val_r, out_root_r});
  assign out_tuser  = {out_err_r, out_zero_r};

endmodule

`default_nettype wire

// File: sv/cbrf_horner.sv
// ----------------------------------------------------------------------------
// cbrf_horner
// Exact cubic evaluation in Horner form, p(x) scaled by 2^(3*FRAC), on one
// shared chunked multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module cbrf_horner (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cbrf_pkg::coeff_t    coeff,
  input  wire cbrf_pkg::eval_req_t req,
  output cbrf_pkg::eval_rsp_t      rsp
);

  typedef enum logic [4:0] {
    H_IDLE  = 5'b00001,
    H_PREP  = 5'b00010,
    H_MUL   = 5'b00100,
    H_DRAIN = 5'b01000,
    H_ADD   = 5'b10000
  } hstate_t;

  hstate_t state_r;
  logic [cbrf_pkg::CNT_W-1:0]  ch_r;
  logic [1:0]                  step_r;
  logic                        pv_r;
  logic                        done_r;

  logic [cbrf_pkg::ACC_W-1:0]  acc_r;
  logic [cbrf_pkg::MAG_W-1:0]  mag_r;
  logic [cbrf_pkg::X_W-1:0]    mx_r;
  logic                        xneg_r;
  logic                        neg_r;
  logic [cbrf_pkg::PROD_W-1:0] prod_r;
  logic [cbrf_pkg::ACC_W-1:0]  sum_r;

  logic [cbrf_pkg::ACC_W-1:0]  term;
  logic [cbrf_pkg::ACC_W-1:0]  acc_abs;
  logic [cbrf_pkg::X_W-1:0]    x_abs;
  logic [cbrf_pkg::ACC_W-1:0]  sum_step;
  logic [cbrf_pkg::CH_W-1:0]   mag_top;

  // next coefficient, aligned to the running scale
  always_comb begin
    case (step_r)
      2'd0:    term = cbrf_pkg::ACC_W'(coeff.c2) << cbrf_pkg::FRAC;
      2'd1:    term = cbrf_pkg::ACC_W'(coeff.c1) << (2 * cbrf_pkg::FRAC);
      default: term = cbrf_pkg::ACC_W'(coeff.c0) << (3 * cbrf_pkg::FRAC);
    endcase
  end

  assign acc_abs  = acc_r[cbrf_pkg::ACC_W-1] ? (~acc_r + 1'b1) : acc_r;
  assign x_abs    = req.x[cbrf_pkg::X_W-1] ? (~req.x + 1'b1) : req.x;
  assign mag_top  = mag_r[cbrf_pkg::MAG_W-1 -: cbrf_pkg::CH_W];
  assign sum_step = (sum_r << cbrf_pkg::CH_W) + cbrf_pkg::ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      ch_r    <= '0;
      step_r  <= '0;
      pv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        H_IDLE: begin
          if (req.start) begin
            step_r  <= '0;
            state_r <= H_PREP;
          end
        end
        H_PREP: begin
          ch_r    <= cbrf_pkg::CNT_W'(cbrf_pkg::NCH - 1);
          pv_r    <= 1'b0;
          state_r <= H_MUL;
        end
        H_MUL: begin
          pv_r <= 1'b1;
          if (ch_r == '0) begin
            state_r <= H_DRAIN;
          end else begin
            ch_r <= ch_r - 1'b1;
          end
        end
        H_DRAIN: begin
          pv_r    <= 1'b0;
          state_r <= H_ADD;
        end
        H_ADD: begin
          if (step_r == 2'd2) begin
            done_r  <= 1'b1;
            state_r <= H_IDLE;
          end else begin
            step_r  <= step_r + 1'b1;
            state_r <= H_PREP;
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  // datapath: magnitudes through the multiplier, sign restored on the add
  always_ff @(posedge clk) begin
    case (state_r)
      H_IDLE: begin
        if (req.start) begin
          acc_r  <= cbrf_pkg::ACC_W'(coeff.c3);
          xneg_r <= req.x[cbrf_pkg::X_W-1];
          mx_r   <= x_abs;
        end
      end
      H_PREP: begin
        mag_r <= cbrf_pkg::MAG_W'(acc_abs);
        neg_r <= acc_r[cbrf_pkg::ACC_W-1] ^ xneg_r;
        sum_r <= '0;
      end
      H_MUL: begin
        prod_r <= cbrf_pkg::PROD_W'(mag_top) * cbrf_pkg::PROD_W'(mx_r);
        mag_r  <= mag_r << cbrf_pkg::CH_W;
        if (pv_r) begin
          sum_r <= sum_step;
        end
      end
      H_DRAIN: begin
        sum_r <= sum_step;
      end
      H_ADD: begin
        acc_r <= (neg_r ? ~sum_r : sum_r) + term + cbrf_pkg::ACC_W'(neg_r);
      end
      default: begin
      end
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.value = acc_r;

endmodule

`default_nettype wire

// File: sv/cbrf_checker.sv
// ----------------------------------------------------------------------------
// cbrf_checker
// Port-level checks on the root finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbrf_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [cbrf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input wire logic [cbrf_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high after accept");

  // no result right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid) ##1 !$rose(out_tvalid))
    else $error("result too soon after accept");

  // exact root and bracket error exclude each other
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("exact_zero and bracket_error both set");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser)))
    else $error("stalled result word changed");

  // reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("not idle after reset");

endmodule

bind cubic_bisection_root_finder cbrf_checker u_cbrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
